/* sv/dce_pkg.sv */
// ----------------------------------------------------------------------------
// Delta chunk enumerator package
// Widths, codes, state type and datapath structures shared by the enumerator,
// its step unit and its checker.
// ----------------------------------------------------------------------------
package dce_pkg;

   localparam int unsigned COORD_WIDTH     = 21;
   localparam int unsigned CELL_WIDTH      = COORD_WIDTH + 1;
   localparam int unsigned SLICE_WIDTH     = COORD_WIDTH + 1;
   localparam int unsigned ALU_WIDTH       = COORD_WIDTH + 2;
   localparam int unsigned RADIUS_WIDTH    = 5;
   localparam int unsigned OFFSET_WIDTH    = RADIUS_WIDTH + 1;
   localparam int unsigned AXES            = 3;
   localparam int unsigned AXIS_WIDTH      = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_MAX   = RADIUS_WIDTH'(31);
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(8);

   localparam logic [AXIS_WIDTH-1:0] AXIS_X    = AXIS_WIDTH'(0);
   localparam logic [AXIS_WIDTH-1:0] AXIS_Y    = AXIS_WIDTH'(1);
   localparam logic [AXIS_WIDTH-1:0] AXIS_Z    = AXIS_WIDTH'(2);
   localparam logic [AXIS_WIDTH-1:0] AXIS_DONE = AXIS_WIDTH'(3);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS_X = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS_Y = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS_Z = CSR_INDEX_WIDTH'(2);

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_DELTA,
      ST_LOAD_MAG,
      ST_ENTER,
      ST_SLICE,
      ST_NEXT_SLICE,
      ST_SKIP_K2,
      ST_SKIP_K1,
      ST_CELL_K,
      ST_CELL_K1,
      ST_CELL_K2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ALU_WIDTH-1:0]    op_a;
      logic [ALU_WIDTH-1:0]    op_b;
      logic                    sub;
      logic [OFFSET_WIDTH-1:0] limit;
      logic [SLICE_WIDTH-1:0]  probe;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_WIDTH-1:0] sum;
      logic                 neg;
      logic                 over;
      logic                 reach;
   } alu_rsp_type;

   function automatic logic [ALU_WIDTH-1:0] sext_coord(input logic [COORD_WIDTH-1:0] v);
      return {{(ALU_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   function automatic logic [ALU_WIDTH-1:0] sext_cell(input logic [CELL_WIDTH-1:0] v);
      return {{(ALU_WIDTH-CELL_WIDTH){v[CELL_WIDTH-1]}}, v};
   endfunction

   function automatic logic [ALU_WIDTH-1:0] zext_slice(input logic [SLICE_WIDTH-1:0] v);
      return {{(ALU_WIDTH-SLICE_WIDTH){1'b0}}, v};
   endfunction

   function automatic logic [ALU_WIDTH-1:0] zext_offset(input logic [OFFSET_WIDTH-1:0] v);
      return {{(ALU_WIDTH-OFFSET_WIDTH){1'b0}}, v};
   endfunction

   function automatic logic [ALU_WIDTH-1:0] sext_rel(input logic [OFFSET_WIDTH:0] v);
      return {{(ALU_WIDTH-OFFSET_WIDTH-1){v[OFFSET_WIDTH]}}, v};
   endfunction

endpackage

/* sv/dce_step_unit.sv */
// ----------------------------------------------------------------------------
// Delta chunk enumerator step unit
// Shared add/subtract unit with the range flags the sequencer tests on its
// result: sign, above a small limit, and not above a slice offset probe.
// ----------------------------------------------------------------------------
module dce_step_unit (
   input  dce_pkg::alu_req_type req,
   output dce_pkg::alu_rsp_type rsp
);
   import dce_pkg::*;

   logic [ALU_WIDTH-1:0] sum;

   assign sum = req.op_a + (req.op_b ^ {ALU_WIDTH{req.sub}}) + ALU_WIDTH'(req.sub);

   assign rsp.sum   = sum;
   assign rsp.neg   = sum[ALU_WIDTH-1];
   assign rsp.over  = $signed(sum) > $signed(zext_offset(req.limit));
   assign rsp.reach = $signed(zext_slice(req.probe)) >= $signed(sum);

endmodule

/* sv/delta_chunk_enumerator_unit.sv */
// ----------------------------------------------------------------------------
// Delta chunk enumerator
// Lists the cells of the box around a new center that lie outside the box
// around the old center, one cell per next command.
//
// A word is taken on the request channel when start is high and busy is low.
// A start word loads both centers and gives no response; the block stays busy
// while it forms the per-axis deltas and finds the first moved axis. A next
// word gives exactly one response word, shown for one cycle with rsp_valid:
// either a cell with rsp_found high, or rsp_found low with zero coordinates
// once the list is exhausted. Delta, magnitude, slice and cell arithmetic goes
// through the one shared step unit, one add per cycle; an emitted cell is
// formed in the cell_k, cell_k1 and cell_k2 steps after the slice check, and
// skipped cells, row wraps, slice wraps and axis changes lengthen the search.
// A next word with nothing to enumerate answers from the finish state. The
// radii are written on the csr channel, which is always ready. Reset returns
// the radii to 8 and clears the enumeration. Responses cannot be held off.
// ----------------------------------------------------------------------------
module delta_chunk_enumerator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_old_x,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_old_y,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_old_z,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_new_x,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_new_y,
   input  logic [dce_pkg::COORD_WIDTH-1:0]      req_new_z,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic [dce_pkg::CELL_WIDTH-1:0]       rsp_cell_x,
   output logic [dce_pkg::CELL_WIDTH-1:0]       rsp_cell_y,
   output logic [dce_pkg::CELL_WIDTH-1:0]       rsp_cell_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dce_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dce_pkg::RADIUS_WIDTH-1:0]     csr_data
);
   import dce_pkg::*;

   state_type                state_ff, state_in;
   logic                     active_ff, active_in;
   logic                     serving_next_ff, serving_next_in;
   logic [AXIS_WIDTH-1:0]    axis_ff, axis_in;
   logic [SLICE_WIDTH-1:0]   slice_ff, slice_in;
   logic [OFFSET_WIDTH-1:0]  first_ff, first_in;
   logic [OFFSET_WIDTH-1:0]  second_ff, second_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [CELL_WIDTH-1:0]    rsp_cell_x_ff, rsp_cell_x_in;
   logic [CELL_WIDTH-1:0]    rsp_cell_y_ff, rsp_cell_y_in;
   logic [CELL_WIDTH-1:0]    rsp_cell_z_ff, rsp_cell_z_in;
   logic [CELL_WIDTH-1:0]    cell_k_ff, cell_k_in;
   logic [CELL_WIDTH-1:0]    cell_k1_ff, cell_k1_in;

   logic [RADIUS_WIDTH-1:0]  radius_ff [AXES];
   logic [COORD_WIDTH-1:0]   old_ff [AXES];
   logic [COORD_WIDTH-1:0]   new_ff [AXES];
   logic [CELL_WIDTH-1:0]    delta_ff [AXES];
   logic [SLICE_WIDTH-1:0]   mag_ff [AXES];

   logic                     accept;
   logic                     delta_we;
   logic                     mag_we;
   logic [RADIUS_WIDTH-1:0]  csr_radius;
   logic [AXIS_WIDTH-1:0]    axis_k1;
   logic [AXIS_WIDTH-1:0]    axis_k2;
   logic [AXIS_WIDTH-1:0]    sel_axis;
   logic [RADIUS_WIDTH-1:0]  r_k;
   logic [RADIUS_WIDTH-1:0]  r_k1;
   logic [RADIUS_WIDTH-1:0]  r_k2;
   logic [OFFSET_WIDTH-1:0]  r_k_plus;
   logic [OFFSET_WIDTH-1:0]  two_r_k1;
   logic [OFFSET_WIDTH-1:0]  two_r_k2;
   logic [OFFSET_WIDTH:0]    first_rel;
   logic [OFFSET_WIDTH:0]    second_rel;
   logic [COORD_WIDTH-1:0]   old_sel;
   logic [COORD_WIDTH-1:0]   new_sel;
   logic [CELL_WIDTH-1:0]    delta_sel;
   logic [SLICE_WIDTH-1:0]   mag_sel;
   alu_req_type              alu_req;
   alu_rsp_type              alu_rsp;

   dce_step_unit u_step (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign csr_radius = (csr_data > RADIUS_MAX) ? RADIUS_MAX : csr_data;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_cell_x = rsp_cell_x_ff;
   assign rsp_cell_y = rsp_cell_y_ff;
   assign rsp_cell_z = rsp_cell_z_ff;

   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            axis_k1 = AXIS_Y;
            axis_k2 = AXIS_Z;
            r_k     = radius_ff[0];
            r_k1    = radius_ff[1];
            r_k2    = radius_ff[2];
         end
         AXIS_Y: begin
            axis_k1 = AXIS_Z;
            axis_k2 = AXIS_X;
            r_k     = radius_ff[1];
            r_k1    = radius_ff[2];
            r_k2    = radius_ff[0];
         end
         AXIS_Z: begin
            axis_k1 = AXIS_X;
            axis_k2 = AXIS_Y;
            r_k     = radius_ff[2];
            r_k1    = radius_ff[0];
            r_k2    = radius_ff[1];
         end
         default: begin
            axis_k1 = AXIS_X;
            axis_k2 = AXIS_X;
            r_k     = radius_ff[0];
            r_k1    = radius_ff[0];
            r_k2    = radius_ff[0];
         end
      endcase
   end

   always_comb begin
      unique case (state_ff) inside
         ST_SKIP_K1, ST_CELL_K1: sel_axis = axis_k1;
         ST_SKIP_K2, ST_CELL_K2: sel_axis = axis_k2;
         default:                sel_axis = (axis_ff == AXIS_DONE) ? AXIS_X : axis_ff;
      endcase
   end

   assign old_sel    = old_ff[sel_axis];
   assign new_sel    = new_ff[sel_axis];
   assign delta_sel  = delta_ff[sel_axis];
   assign mag_sel    = mag_ff[sel_axis];

   assign r_k_plus   = {1'b0, r_k} + 1'b1;
   assign two_r_k1   = {r_k1, 1'b0};
   assign two_r_k2   = {r_k2, 1'b0};
   assign first_rel  = {1'b0, first_ff} - {2'b00, r_k1};
   assign second_rel = {1'b0, second_ff} - {2'b00, r_k2};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_START) begin
                  state_in = ST_LOAD_DELTA;
               end else if (active_ff) begin
                  state_in = ST_SLICE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOAD_DELTA: state_in = ST_LOAD_MAG;
         ST_LOAD_MAG: begin
            state_in = (axis_ff == AXIS_Z) ? ST_ENTER : ST_LOAD_DELTA;
         end
         ST_ENTER: begin
            if (axis_ff == AXIS_DONE) begin
               state_in = serving_next_ff ? ST_FINISH : ST_IDLE;
            end else if (delta_sel != '0) begin
               state_in = serving_next_ff ? ST_SLICE : ST_IDLE;
            end
         end
         ST_SLICE: begin
            if (alu_rsp.reach) begin
               state_in = ST_ENTER;
            end else if (first_ff > two_r_k1) begin
               state_in = ST_NEXT_SLICE;
            end else if (second_ff > two_r_k2) begin
               state_in = ST_SLICE;
            end else if (axis_ff != AXIS_X) begin
               state_in = ST_SKIP_K2;
            end else begin
               state_in = ST_CELL_K;
            end
         end
         ST_NEXT_SLICE: state_in = ST_SLICE;
         ST_SKIP_K2: begin
            if (alu_rsp.neg || alu_rsp.over) begin
               state_in = ST_SLICE;
            end else if (axis_ff == AXIS_Z) begin
               state_in = ST_SKIP_K1;
            end else begin
               state_in = ST_CELL_K;
            end
         end
         ST_SKIP_K1: begin
            state_in = (alu_rsp.neg || alu_rsp.over) ? ST_SLICE : ST_CELL_K;
         end
         ST_CELL_K:  state_in = ST_CELL_K1;
         ST_CELL_K1: state_in = ST_CELL_K2;
         ST_CELL_K2: state_in = ST_IDLE;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      alu_req         = '0;
      active_in       = active_ff;
      serving_next_in = serving_next_ff;
      axis_in         = axis_ff;
      slice_in        = slice_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      cell_k_in       = cell_k_ff;
      cell_k1_in      = cell_k1_ff;
      delta_we        = 1'b0;
      mag_we          = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_cell_x_in   = rsp_cell_x_ff;
      rsp_cell_y_in   = rsp_cell_y_ff;
      rsp_cell_z_in   = rsp_cell_z_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               serving_next_in = (req_command == CMD_NEXT);
               if (req_command == CMD_START) begin
                  active_in = 1'b1;
                  axis_in   = AXIS_X;
               end
            end
         end
         ST_LOAD_DELTA: begin
            alu_req.op_a = sext_coord(new_sel);
            alu_req.op_b = sext_coord(old_sel);
            alu_req.sub  = 1'b1;
            delta_we     = 1'b1;
         end
         ST_LOAD_MAG: begin
            alu_req.op_b = sext_cell(delta_sel);
            alu_req.sub  = delta_sel[CELL_WIDTH-1];
            mag_we       = 1'b1;
            axis_in      = (axis_ff == AXIS_Z) ? AXIS_X : axis_ff + 1'b1;
         end
         ST_ENTER: begin
            alu_req.op_a  = zext_slice(mag_sel);
            alu_req.op_b  = zext_offset({1'b0, r_k});
            alu_req.sub   = 1'b1;
            alu_req.limit = {1'b0, r_k};
            if (axis_ff == AXIS_DONE) begin
               active_in = 1'b0;
            end else if (delta_sel == '0) begin
               axis_in = axis_ff + 1'b1;
            end else begin
               slice_in  = alu_rsp.over ? alu_rsp.sum[SLICE_WIDTH-1:0]
                                        : {{(SLICE_WIDTH-OFFSET_WIDTH){1'b0}}, r_k_plus};
               first_in  = '0;
               second_in = '0;
            end
         end
         ST_SLICE: begin
            alu_req.op_a  = zext_slice(mag_sel);
            alu_req.op_b  = zext_offset(r_k_plus);
            alu_req.probe = slice_ff;
            if (alu_rsp.reach) begin
               axis_in = axis_ff + 1'b1;
            end else if (first_ff > two_r_k1) begin
               first_in  = '0;
               second_in = '0;
            end else if (second_ff > two_r_k2) begin
               second_in = '0;
               first_in  = first_ff + 1'b1;
            end
         end
         ST_NEXT_SLICE: begin
            alu_req.op_a = zext_slice(slice_ff);
            alu_req.op_b = {{(ALU_WIDTH-1){1'b0}}, 1'b1};
            slice_in     = alu_rsp.sum[SLICE_WIDTH-1:0];
         end
         ST_SKIP_K2: begin
            alu_req.op_a  = sext_cell(delta_sel);
            alu_req.op_b  = zext_offset(second_ff);
            alu_req.limit = two_r_k2;
            if (alu_rsp.neg || alu_rsp.over) begin
               second_in = second_ff + 1'b1;
            end
         end
         ST_SKIP_K1: begin
            alu_req.op_a  = sext_cell(delta_sel);
            alu_req.op_b  = zext_offset(first_ff);
            alu_req.limit = two_r_k1;
            if (alu_rsp.neg || alu_rsp.over) begin
               second_in = second_ff + 1'b1;
            end
         end
         ST_CELL_K: begin
            alu_req.op_a = sext_coord(old_sel);
            alu_req.op_b = zext_slice(slice_ff);
            alu_req.sub  = delta_sel[CELL_WIDTH-1];
            cell_k_in    = alu_rsp.sum[CELL_WIDTH-1:0];
         end
         ST_CELL_K1: begin
            alu_req.op_a = sext_coord(new_sel);
            alu_req.op_b = sext_rel(first_rel);
            cell_k1_in   = alu_rsp.sum[CELL_WIDTH-1:0];
         end
         ST_CELL_K2: begin
            alu_req.op_a = sext_coord(new_sel);
            alu_req.op_b = sext_rel(second_rel);
            second_in    = second_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            unique case (axis_ff)
               AXIS_X: begin
                  rsp_cell_x_in = cell_k_ff;
                  rsp_cell_y_in = cell_k1_ff;
                  rsp_cell_z_in = alu_rsp.sum[CELL_WIDTH-1:0];
               end
               AXIS_Y: begin
                  rsp_cell_y_in = cell_k_ff;
                  rsp_cell_z_in = cell_k1_ff;
                  rsp_cell_x_in = alu_rsp.sum[CELL_WIDTH-1:0];
               end
               AXIS_Z: begin
                  rsp_cell_z_in = cell_k_ff;
                  rsp_cell_x_in = cell_k1_ff;
                  rsp_cell_y_in = alu_rsp.sum[CELL_WIDTH-1:0];
               end
               default: begin
                  rsp_cell_x_in = '0;
                  rsp_cell_y_in = '0;
                  rsp_cell_z_in = '0;
               end
            endcase
         end
         ST_FINISH: begin
            active_in     = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_cell_x_in = '0;
            rsp_cell_y_in = '0;
            rsp_cell_z_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= 1'b0;
         serving_next_ff <= 1'b0;
         axis_ff         <= AXIS_X;
         slice_ff        <= '0;
         first_ff        <= '0;
         second_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         serving_next_ff <= serving_next_in;
         axis_ff         <= axis_in;
         slice_ff        <= slice_in;
         first_ff        <= first_in;
         second_ff       <= second_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff[0] <= RADIUS_RESET;
         radius_ff[1] <= RADIUS_RESET;
         radius_ff[2] <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIUS_X: radius_ff[0] <= csr_radius;
            CSR_RADIUS_Y: radius_ff[1] <= csr_radius;
            CSR_RADIUS_Z: radius_ff[2] <= csr_radius;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_cell_x_ff <= rsp_cell_x_in;
      rsp_cell_y_ff <= rsp_cell_y_in;
      rsp_cell_z_ff <= rsp_cell_z_in;
      cell_k_ff     <= cell_k_in;
      cell_k1_ff    <= cell_k1_in;
      if (accept && (req_command == CMD_START)) begin
         old_ff[0] <= req_old_x;
         old_ff[1] <= req_old_y;
         old_ff[2] <= req_old_z;
         new_ff[0] <= req_new_x;
         new_ff[1] <= req_new_y;
         new_ff[2] <= req_new_z;
      end
      if (delta_we) begin
         delta_ff[sel_axis] <= alu_rsp.sum[CELL_WIDTH-1:0];
      end
      if (mag_we) begin
         mag_ff[sel_axis] <= alu_rsp.sum[SLICE_WIDTH-1:0];
      end
   end

endmodule

/* sv/dce_checker.sv */
// ----------------------------------------------------------------------------
// Delta chunk enumerator checker
// Port-level properties of the enumerator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dce_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_command,
   input logic                            rsp_valid,
   input logic                            rsp_found,
   input logic [dce_pkg::CELL_WIDTH-1:0]  rsp_cell_x,
   input logic [dce_pkg::CELL_WIDTH-1:0]  rsp_cell_y,
   input logic [dce_pkg::CELL_WIDTH-1:0]  rsp_cell_z
);
   import dce_pkg::*;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Response word shown while the block is busy.");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_START)) |=> !rsp_valid)
      else $error("Start word produced a response.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block not busy after accepting a word.");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         ((rsp_cell_x == '0) && (rsp_cell_y == '0) && (rsp_cell_z == '0)))
      else $error("Finished response carries nonzero coordinates.");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two response words in consecutive cycles.");

endmodule

bind delta_chunk_enumerator_unit dce_checker u_dce_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_found   (rsp_found),
   .rsp_cell_x  (rsp_cell_x),
   .rsp_cell_y  (rsp_cell_y),
   .rsp_cell_z  (rsp_cell_z)
);
